// File: rtl/core/stxp_pkg.sv
// ----------------------------------------------------------------------------
// stxp_pkg
// Shared types and constants for the STX/ETX frame parser core.
// ----------------------------------------------------------------------------
package stxp_pkg;

  // framing bytes and header overheads
  localparam logic [7:0]  START_BYTE       = 8'h02;
  localparam logic [7:0]  END_BYTE         = 8'h03;
  localparam logic [31:0] OVERHEAD_PLAIN   = 32'd11;
  localparam logic [31:0] OVERHEAD_CRC     = 32'd15;
  localparam logic [31:0] MAX_LENGTH_RESET = 32'd1000000;

  // result kinds
  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_DROP   = 2'd2;

  // drop causes
  localparam logic [2:0] CAUSE_NONE  = 3'd0;
  localparam logic [2:0] CAUSE_LONG  = 3'd1;
  localparam logic [2:0] CAUSE_SHORT = 3'd2;
  localparam logic [2:0] CAUSE_END   = 3'd3;
  localparam logic [2:0] CAUSE_CRC   = 3'd4;

  // width of the packed result data word (83 bits padded to bytes)
  localparam int unsigned RES_DATA_W = 88;

  // one result word
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [7:0]  flags;
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] count;
    logic [2:0]  cause;
  } result_t;

endpackage

// File: rtl/core/stx_etx_frame_parser_core.sv
// ----------------------------------------------------------------------------
// stx_etx_frame_parser_core
// STX/ETX framed byte stream parser: payload words plus accept/drop results.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                                  tuser
//  s_axis    in   [7:0] rx_byte                          [0] stream_lost
//  m_axis    out  [7:0] payload_byte, [15:8] flags,      [1:0] result_kind
//                 [31:16] src, [47:32] dst,
//                 [79:48] payload_count, [82:80] cause
//  cfg       in   cfg_wr_data = max_frame_length, written when cfg_wr_en
//
//  One input word per cycle while m_axis does not stall; a result word passes
//  through the input register, then the parser step, then the result register,
//  before it is offered on m_axis.
//  Words that make no result (header, hunting, lost stream) are absorbed.
//  m_axis stalls back-pressure s_axis once both registers are full.
//  rst is synchronous; max_frame_length resets to 1000000.
// ----------------------------------------------------------------------------
module stx_etx_frame_parser_core (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [0:0]  s_axis_tuser,   // [0] stream_lost
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [stxp_pkg::RES_DATA_W-1:0] m_axis_tdata,
                                      // payload_byte, frame_flags, source_address,
                                      // destination_address, payload_count,
                                      // drop_cause, zero pad
  output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic [31:0]       max_frame_length;
  logic              res_valid;
  logic              res_ready;
  stxp_pkg::result_t res;
  stxp_pkg::result_t res_q;

  // length limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_length <= stxp_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_frame_length <= cfg_wr_data;
    end
  end

  stxp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_tvalid (s_axis_tvalid),
    .in_tready (s_axis_tready),
    .in_byte   (s_axis_tdata),
    .in_lost   (s_axis_tuser[0]),
    .max_len   (max_frame_length),
    .res_ready (res_ready),
    .res_valid (res_valid),
    .res       (res)
  );

  stxp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res_in    (res),
    .ready     (res_ready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .res_out   (res_q)
  );

  // output packing, lowest field first
  assign m_axis_tdata = {5'd0, res_q.cause, res_q.count, res_q.dst,
                         res_q.src, res_q.flags, res_q.data};
  assign m_axis_tuser = res_q.kind;

endmodule

// File: rtl/core/stxp_parser.sv
// ----------------------------------------------------------------------------
// stxp_parser
// Input word register and frame state machine; produces at most one result
// word for each input word it consumes.
// ----------------------------------------------------------------------------
module stxp_parser (
  input  logic                 clk,
  input  logic                 rst,
  // input word side
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_byte,
  input  logic                 in_lost,
  // configuration
  input  logic [31:0]          max_len,
  // result side
  input  logic                 res_ready,
  output logic                 res_valid,
  output stxp_pkg::result_t    res
);

  // phase codes
  localparam logic [2:0] PH_HUNT    = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_FLAGS   = 3'd2;
  localparam logic [2:0] PH_SRC     = 3'd3;
  localparam logic [2:0] PH_DST     = 3'd4;
  localparam logic [2:0] PH_PAYLOAD = 3'd5;
  localparam logic [2:0] PH_ETX     = 3'd6;
  localparam logic [2:0] PH_CRC     = 3'd7;

  // input register
  logic        in_valid;
  logic [7:0]  in_b;
  logic        in_l;
  logic        fire;

  // frame state
  logic [2:0]  phase,       phase_next;
  logic [1:0]  idx,         idx_next;
  logic [31:0] total_len,   total_len_next;
  logic        crc_follows, crc_follows_next;
  logic [7:0]  flags_held,  flags_held_next;
  logic [15:0] src_held,    src_held_next;
  logic [15:0] dst_held,    dst_held_next;
  logic [31:0] bytes_rem,   bytes_rem_next;
  logic [31:0] pay_len,     pay_len_next;

  logic [31:0] len_shift;
  logic        clear;

  assign fire      = in_valid && res_ready;
  assign in_tready = !in_valid || fire;
  assign len_shift = {total_len[23:0], in_b};

  // input word register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_tready) begin
      in_valid <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_b <= in_byte;
      in_l <= in_lost;
    end
  end

  // one step of the frame parser
  always_comb begin
    phase_next       = phase;
    idx_next         = idx;
    total_len_next   = total_len;
    crc_follows_next = crc_follows;
    flags_held_next  = flags_held;
    src_held_next    = src_held;
    dst_held_next    = dst_held;
    bytes_rem_next   = bytes_rem;
    pay_len_next     = pay_len;
    clear            = 1'b0;
    res_valid        = 1'b0;
    res.kind         = stxp_pkg::KIND_DATA;
    res.data         = 8'd0;
    res.flags        = flags_held;
    res.src          = src_held;
    res.dst          = dst_held;
    res.count        = pay_len;
    res.cause        = stxp_pkg::CAUSE_NONE;

    if (!in_valid) begin
      // empty input register: no step, no result
      res_valid = 1'b0;
    end else if (in_l) begin
      clear = 1'b1;
    end else begin
      case (phase)
        PH_HUNT: begin
          if (in_b == stxp_pkg::START_BYTE) begin
            phase_next = PH_LEN;
          end
        end
        PH_LEN: begin
          total_len_next = len_shift;
          if (idx != 2'd3) begin
            idx_next = idx + 2'd1;
          end else if (len_shift > max_len) begin
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_DROP;
            res.cause = stxp_pkg::CAUSE_LONG;
            clear     = 1'b1;
          end else if (len_shift < stxp_pkg::OVERHEAD_PLAIN) begin
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_DROP;
            res.cause = stxp_pkg::CAUSE_SHORT;
            clear     = 1'b1;
          end else begin
            idx_next   = 2'd0;
            phase_next = PH_FLAGS;
          end
        end
        PH_FLAGS: begin
          flags_held_next  = in_b;
          crc_follows_next = in_b[0];
          if (in_b[0] && (total_len < stxp_pkg::OVERHEAD_CRC)) begin
            // short CRC frame reports the flags just read
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_DROP;
            res.flags = in_b;
            res.cause = stxp_pkg::CAUSE_SHORT;
            clear     = 1'b1;
          end else begin
            pay_len_next = total_len - (in_b[0] ? stxp_pkg::OVERHEAD_CRC
                                                : stxp_pkg::OVERHEAD_PLAIN);
            idx_next     = 2'd0;
            phase_next   = PH_SRC;
          end
        end
        PH_SRC: begin
          src_held_next = {src_held[7:0], in_b};
          if (idx == 2'd0) begin
            idx_next = 2'd1;
          end else begin
            idx_next   = 2'd0;
            phase_next = PH_DST;
          end
        end
        PH_DST: begin
          dst_held_next = {dst_held[7:0], in_b};
          if (idx == 2'd0) begin
            idx_next = 2'd1;
          end else begin
            idx_next       = 2'd0;
            bytes_rem_next = pay_len;
            phase_next     = (pay_len == 32'd0) ? PH_ETX : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          res_valid      = 1'b1;
          res.kind       = stxp_pkg::KIND_DATA;
          res.data       = in_b;
          bytes_rem_next = bytes_rem - 32'd1;
          if (bytes_rem == 32'd1) begin
            phase_next = PH_ETX;
          end
        end
        PH_ETX: begin
          if (in_b != stxp_pkg::END_BYTE) begin
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_DROP;
            res.cause = stxp_pkg::CAUSE_END;
            clear     = 1'b1;
          end else if (!crc_follows) begin
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_ACCEPT;
            clear     = 1'b1;
          end else begin
            idx_next   = 2'd0;
            phase_next = PH_CRC;
          end
        end
        PH_CRC: begin
          if (idx != 2'd3) begin
            idx_next = idx + 2'd1;
          end else begin
            res_valid = 1'b1;
            res.kind  = stxp_pkg::KIND_DROP;
            res.cause = stxp_pkg::CAUSE_CRC;
            clear     = 1'b1;
          end
        end
        default: begin
          clear = 1'b1;
        end
      endcase
    end

    // end of frame, dropped frame or lost stream: back to hunting with clean state
    if (clear) begin
      phase_next       = PH_HUNT;
      idx_next         = 2'd0;
      total_len_next   = 32'd0;
      crc_follows_next = 1'b0;
      flags_held_next  = 8'd0;
      src_held_next    = 16'd0;
      dst_held_next    = 16'd0;
      bytes_rem_next   = 32'd0;
      pay_len_next     = 32'd0;
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HUNT;
      idx         <= 2'd0;
      total_len   <= 32'd0;
      crc_follows <= 1'b0;
      flags_held  <= 8'd0;
      src_held    <= 16'd0;
      dst_held    <= 16'd0;
      bytes_rem   <= 32'd0;
      pay_len     <= 32'd0;
    end else if (fire) begin
      phase       <= phase_next;
      idx         <= idx_next;
      total_len   <= total_len_next;
      crc_follows <= crc_follows_next;
      flags_held  <= flags_held_next;
      src_held    <= src_held_next;
      dst_held    <= dst_held_next;
      bytes_rem   <= bytes_rem_next;
      pay_len     <= pay_len_next;
    end
  end

  // checks
  a_data_no_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && res_valid && res.kind == stxp_pkg::KIND_DATA)
      |-> res.cause == stxp_pkg::CAUSE_NONE)
    else $error("payload word carries a drop cause");

  a_drop_has_cause: assert property (@(posedge clk) disable iff (rst)
    (in_valid && res_valid && res.kind == stxp_pkg::KIND_DROP)
      |-> res.cause != stxp_pkg::CAUSE_NONE)
    else $error("drop without a cause");

  a_hunt_clean: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_HUNT) |-> (bytes_rem == 32'd0 && pay_len == 32'd0
                            && flags_held == 8'd0))
    else $error("frame state not cleared while hunting");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_PAYLOAD) |-> (bytes_rem != 32'd0))
    else $error("payload phase with no bytes left");

  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(phase) && $stable(bytes_rem))
    else $error("parser state moved without a consumed word");

endmodule

// File: rtl/core/stxp_out_reg.sv
// ----------------------------------------------------------------------------
// stxp_out_reg
// Result register: holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module stxp_out_reg (
  input  logic              clk,
  input  logic              rst,
  // from parser
  input  logic              load,
  input  stxp_pkg::result_t res_in,
  output logic              ready,
  // downstream
  output logic              out_valid,
  input  logic              out_ready,
  output stxp_pkg::result_t res_out
);

  // free when empty or being drained this cycle
  assign ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
    if (ready && load) begin
      res_out <= res_in;
    end
  end

endmodule
